/* rtl/assert_macros.svh */
// Assertion macros shared by the sparse triplet table RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define STAT_ASSERT_HOLDS(label, ck, rs, cond, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define STAT_ASSERT_IMPLIES(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define STAT_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/stat_pkg.sv */
// Shared types and codes for the sparse triplet accumulate table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stat_pkg;

  localparam int unsigned KEY_FIELD_W   = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_FIELD_W = 6;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_EMIT  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ADD,
    OP_EMIT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [KEY_FIELD_W-1:0]    entry_row;
    logic [KEY_FIELD_W-1:0]    entry_col;
    logic signed [VALUE_W-1:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0]    out_row;
    logic [KEY_FIELD_W-1:0]    out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      entry_valid;
    logic                      last_entry;
    logic [COUNT_FIELD_W-1:0]  stored_count;
    logic                      overflowed;
  } result_t;

  // Decoded operation passed from the front end to the executor.
  typedef struct packed {
    op_e                       op;
    logic [KEY_FIELD_W-1:0]    row;
    logic [KEY_FIELD_W-1:0]    col;
    logic signed [VALUE_W-1:0] value;
  } op_t;

endpackage

/* rtl/stat_front.sv */
// Front end: accepts input beats, decodes the command and masks the indices.
// Depends on stat_pkg.
`timescale 1ns / 1ps

module stat_front #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  stat_pkg::item_t item,
  output logic            op_valid,
  input  logic            op_stall,
  output stat_pkg::op_t   op
);
  import stat_pkg::*;

  localparam int unsigned KEY_W = (INDEX_WIDTH < KEY_FIELD_W) ? INDEX_WIDTH : KEY_FIELD_W;

  logic hold_valid;
  op_t  hold;
  op_t  decoded;
  op_e  kind;

  always_comb begin
    unique case (item.cmd)
      CMD_LOAD:  kind = OP_LOAD;
      CMD_ADD:   kind = OP_ADD;
      CMD_EMIT:  kind = OP_EMIT;
      CMD_CLEAR: kind = OP_CLEAR;
    endcase
    decoded.op    = kind;
    // Only the low index bits take part in storage and matching.
    decoded.row   = KEY_FIELD_W'(item.entry_row[KEY_W-1:0]);
    decoded.col   = KEY_FIELD_W'(item.entry_col[KEY_W-1:0]);
    decoded.value = item.entry_value;
  end

  // The holding register is free when empty or when it drains this cycle.
  assign item_stall = hold_valid && op_stall;
  assign op_valid   = hold_valid;
  assign op         = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold <= decoded;
    end
  end

endmodule

/* rtl/stat_queue.sv */
// Two-entry queue of decoded operations between the front end and the executor.
// Depends on stat_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stat_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  stat_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_stall,
  output stat_pkg::op_t pop_op
);
  import stat_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = 1;

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_stall = (count == (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  `STAT_ASSERT_HOLDS(a_queue_bound, clk, rst, count <= (PTR_W + 1)'(DEPTH), "queue count beyond depth")
  `STAT_ASSERT_NEXT(a_queue_grow, clk, rst, push && !pop, count == $past(count) + (PTR_W + 1)'(1), "queue count did not follow a push")

endmodule

/* rtl/stat_back.sv */
// Executor: holds the table of entry cells, performs load, add, clear and emit,
// and drives the registered result port. Depends on stat_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stat_back #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_stall,
  input  stat_pkg::op_t     op,
  output logic              result_valid,
  input  logic              result_stall,
  output stat_pkg::result_t result
);
  import stat_pkg::*;

  localparam int unsigned KEY_W = (INDEX_WIDTH < KEY_FIELD_W) ? INDEX_WIDTH : KEY_FIELD_W;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_EMIT
  } state_e;

  state_e state;

  logic [KEY_W-1:0]   cell_row   [TABLE_DEPTH];
  logic [KEY_W-1:0]   cell_col   [TABLE_DEPTH];
  logic [VALUE_W-1:0] cell_value [TABLE_DEPTH];

  logic [CNT_W-1:0]   fill_count;
  logic               overflow_flag;
  logic [IDX_W-1:0]   emit_idx;
  logic [KEY_W-1:0]   cur_row;
  logic [KEY_W-1:0]   cur_col;
  logic [VALUE_W-1:0] cur_value;

  logic [TABLE_DEPTH-1:0] match;
  logic                   hit;
  logic                   has_room;
  logic                   pop;
  logic                   append_req;
  logic                   do_append;
  logic                   ovf_set;
  logic [KEY_W-1:0]       app_row;
  logic [KEY_W-1:0]       app_col;
  logic [VALUE_W-1:0]     app_value;
  logic                   out_free;
  logic                   emit_last;
  result_t                emit_beat;

  assign op_stall = (state != S_IDLE);
  assign pop      = op_valid && (state == S_IDLE);
  assign out_free = !result_valid || !result_stall;
  assign has_room = (fill_count < CNT_W'(TABLE_DEPTH));

  // Every occupied cell compares its key with the pending add in parallel.
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      match[k] = (CNT_W'(k) < fill_count) && (cell_row[k] == cur_row) &&
                 (cell_col[k] == cur_col);
    end
  end
  assign hit = |match;

  assign append_req = (pop && (op.op == OP_LOAD)) || ((state == S_ADD) && !hit);
  assign do_append  = append_req && has_room;
  assign ovf_set    = append_req && !has_room;
  assign app_row    = (state == S_ADD) ? cur_row : op.row[KEY_W-1:0];
  assign app_col    = (state == S_ADD) ? cur_col : op.col[KEY_W-1:0];
  assign app_value  = (state == S_ADD) ? cur_value : op.value;

  always_ff @(posedge clk) begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (do_append && (fill_count[IDX_W-1:0] == IDX_W'(k))) begin
        cell_row[k]   <= app_row;
        cell_col[k]   <= app_col;
        cell_value[k] <= app_value;
      end else if ((state == S_ADD) && match[k]) begin
        cell_value[k] <= cell_value[k] + cur_value;
      end
    end
  end

  // An empty table still answers an emit with a single closing beat.
  assign emit_last = (fill_count == '0) ||
                     ((CNT_W'(emit_idx) + CNT_W'(1)) == fill_count);

  always_comb begin
    emit_beat.stored_count = COUNT_FIELD_W'(fill_count);
    emit_beat.overflowed   = overflow_flag;
    emit_beat.last_entry   = emit_last;
    if (fill_count == '0) begin
      emit_beat.out_row     = '0;
      emit_beat.out_col     = '0;
      emit_beat.out_value   = '0;
      emit_beat.entry_valid = 1'b0;
    end else begin
      emit_beat.out_row     = KEY_FIELD_W'(cell_row[emit_idx]);
      emit_beat.out_col     = KEY_FIELD_W'(cell_col[emit_idx]);
      emit_beat.out_value   = $signed(cell_value[emit_idx]);
      emit_beat.entry_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      overflow_flag <= 1'b0;
      emit_idx      <= '0;
      result_valid  <= 1'b0;
    end else begin
      // While emitting, a freed result register is refilled in the same cycle.
      if (result_valid && !result_stall && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end
      if (do_append) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      if (ovf_set) begin
        overflow_flag <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (op.op)
              OP_LOAD: begin
                // The append itself is handled by the shared append path.
              end
              OP_ADD: begin
                cur_row   <= op.row[KEY_W-1:0];
                cur_col   <= op.col[KEY_W-1:0];
                cur_value <= op.value;
                state     <= S_ADD;
              end
              OP_EMIT: begin
                emit_idx <= '0;
                state    <= S_EMIT;
              end
              OP_CLEAR: begin
                fill_count    <= '0;
                overflow_flag <= 1'b0;
              end
            endcase
          end
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result       <= emit_beat;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `STAT_ASSERT_HOLDS(a_fill_bound, clk, rst, fill_count <= CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
  `STAT_ASSERT_IMPLIES(a_ovf_full, clk, rst, $rose(overflow_flag), $past(fill_count) == CNT_W'(TABLE_DEPTH), "overflow set while the table had room")
  `STAT_ASSERT_IMPLIES(a_empty_last, clk, rst, result_valid && !result.entry_valid, result.last_entry, "empty-table beat not marked last")

endmodule

/* rtl/sparse_triplet_accumulate_table_core.sv */
// Top level of the sparse triplet accumulate table.
// Depends on stat_pkg, stat_front, stat_queue and stat_back.
`timescale 1ns / 1ps

// Sums two sparse matrices held as (row, column, value) triplets in a table of
// TABLE_DEPTH entry cells. A load beat appends a triplet; an add beat is compared
// with every occupied cell at once and its value is added into each match, or
// appended when nothing matches; an emit beat reads the table out in storage
// order, one result beat per entry (one beat with entry_valid low on an empty
// table), the final beat marked last_entry; a clear beat empties the table and
// drops the sticky overflow flag. Appends into a full table are dropped and set
// that flag. The front end accepts one beat per cycle, while the queue has room,
// into a two-entry queue; the executor performs a load or clear as it takes the
// beat, an add by capturing the key and then comparing and updating, and an emit
// by starting the readout and then sending one result beat per entry, at least
// one, each when the result register is free. No clearing pass follows reset.
module sparse_triplet_accumulate_table_core #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  stat_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output stat_pkg::result_t result
);
  import stat_pkg::*;

  logic front_valid;
  logic front_stall;
  op_t  front_op;
  logic back_valid;
  logic back_stall;
  op_t  back_op;

  stat_front #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .op_valid   (front_valid),
    .op_stall   (front_stall),
    .op         (front_op)
  );

  stat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_stall  (back_stall),
    .pop_op     (back_op)
  );

  stat_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (back_valid),
    .op_stall     (back_stall),
    .op           (back_op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* tb/sv/sparse_triplet_accumulate_table_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for sparse_triplet_accumulate_table_core: directed table cases, a long
// output hold-off and random load/add/emit/clear sequences under several idling mixes.
// Depends on stat_pkg and the core RTL; a local copy of the table predicts every emitted beat.

module sparse_triplet_accumulate_table_core_test;
  import stat_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 32;
  localparam int unsigned INDEX_WIDTH     = 16;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned REPORT_LIMIT    = 10;

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // Local image of the triplet table.
  logic [KEY_FIELD_W-1:0] tbl_row   [TABLE_DEPTH];
  logic [KEY_FIELD_W-1:0] tbl_col   [TABLE_DEPTH];
  logic [VALUE_W-1:0]     tbl_value [TABLE_DEPTH];
  int unsigned            tbl_fill     = 0;
  logic                   tbl_overflow = 1'b0;
  result_t                emitted_entries[$];

  int unsigned send_idle_pct    = 0;
  int unsigned recv_stall_pct   = 0;
  logic        hold_off_pending = 1'b0;
  int unsigned hold_left        = 0;
  int unsigned mismatch_count   = 0;
  int unsigned quiet_cycles     = 0;

  sparse_triplet_accumulate_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stalls, or a long hold-off when one has been requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left        = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Ends the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("FAIL sparse_triplet_accumulate_table_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
  endfunction

  function automatic void append_triplet(logic [KEY_FIELD_W-1:0] r, logic [KEY_FIELD_W-1:0] c,
                                         logic [VALUE_W-1:0] v);
    if (tbl_fill < TABLE_DEPTH) begin
      tbl_row[tbl_fill]   = r;
      tbl_col[tbl_fill]   = c;
      tbl_value[tbl_fill] = v;
      tbl_fill++;
    end else begin
      tbl_overflow = 1'b1;
    end
  endfunction

  // Updates the table image for one accepted beat and queues any beats an emit produces.
  function automatic void apply_to_table(item_t it);
    bit      hit;
    result_t beat;
    case (it.cmd)
      CMD_LOAD: append_triplet(it.entry_row, it.entry_col, it.entry_value);
      CMD_ADD: begin
        hit = 1'b0;
        for (int k = 0; k < tbl_fill; k++) begin
          if (tbl_row[k] == it.entry_row && tbl_col[k] == it.entry_col) begin
            tbl_value[k] = tbl_value[k] + it.entry_value;
            hit          = 1'b1;
          end
        end
        if (!hit) append_triplet(it.entry_row, it.entry_col, it.entry_value);
      end
      CMD_EMIT: begin
        beat              = '0;
        beat.overflowed   = tbl_overflow;
        beat.stored_count = tbl_fill[COUNT_FIELD_W-1:0];
        if (tbl_fill == 0) begin
          beat.last_entry = 1'b1;
          emitted_entries.push_back(beat);
        end
        for (int k = 0; k < tbl_fill; k++) begin
          beat.out_row     = tbl_row[k];
          beat.out_col     = tbl_col[k];
          beat.out_value   = tbl_value[k];
          beat.entry_valid = 1'b1;
          beat.last_entry  = (k + 1 == tbl_fill);
          emitted_entries.push_back(beat);
        end
      end
      CMD_CLEAR: begin
        tbl_fill     = 0;
        tbl_overflow = 1'b0;
      end
    endcase
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (emitted_entries.size() == 0) begin
      note_mismatch($sformatf("beat with none expected: row %h col %h value %h",
                              got.out_row, got.out_col, got.out_value));
      return;
    end
    want = emitted_entries.pop_front();
    if (got.out_row !== want.out_row)
      note_mismatch($sformatf("out_row expected %h got %h", want.out_row, got.out_row));
    if (got.out_col !== want.out_col)
      note_mismatch($sformatf("out_col expected %h got %h", want.out_col, got.out_col));
    if (got.out_value !== want.out_value)
      note_mismatch($sformatf("out_value expected %h got %h", want.out_value, got.out_value));
    if (got.entry_valid !== want.entry_valid)
      note_mismatch($sformatf("entry_valid expected %b got %b",
                              want.entry_valid, got.entry_valid));
    if (got.last_entry !== want.last_entry)
      note_mismatch($sformatf("last_entry expected %b got %b", want.last_entry, got.last_entry));
    if (got.stored_count !== want.stored_count)
      note_mismatch($sformatf("stored_count expected %0d got %0d",
                              want.stored_count, got.stored_count));
    if (got.overflowed !== want.overflowed)
      note_mismatch($sformatf("overflowed expected %b got %b", want.overflowed, got.overflowed));
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result);
  end

  // Offers one beat after a random gap and holds it until the core takes it.
  task automatic send_command(logic [1:0] cmd, logic [KEY_FIELD_W-1:0] r,
                              logic [KEY_FIELD_W-1:0] c, logic [VALUE_W-1:0] v);
    item_t it;
    it.cmd         = cmd;
    it.entry_row   = r;
    it.entry_col   = c;
    it.entry_value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    apply_to_table(it);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(3);
      3:       return -$urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_table();
    send_command(CMD_EMIT, 16'($urandom), 16'($urandom), $urandom);
  endtask

  // Extreme keys and values, an add hitting two entries, wrap-around and partial key matches.
  task automatic test_accumulate();
    send_command(CMD_LOAD, 16'h0000, 16'h0000, 32'h8000_0000);
    send_command(CMD_LOAD, 16'hffff, 16'hffff, 32'h7fff_ffff);
    send_command(CMD_LOAD, 16'h0000, 16'h0000, 32'd5);
    send_command(CMD_ADD,  16'h0000, 16'h0000, 32'd1);
    send_command(CMD_ADD,  16'hffff, 16'hffff, 32'd1);
    send_command(CMD_ADD,  16'h0000, 16'hffff, 32'hffff_ffff);
    send_command(CMD_ADD,  16'hffff, 16'h0000, 32'd0);
    send_command(CMD_ADD,  16'h1234, 16'habcd, -32'sd7);
    send_command(CMD_ADD,  16'h1234, 16'habcd, 32'sd7);
    send_command(CMD_EMIT, 16'h5a5a, 16'ha5a5, 32'hdead_beef);
  endtask

  task automatic test_clear();
    send_command(CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom);
    send_command(CMD_EMIT,  16'h0000, 16'h0000, 32'd0);
    send_command(CMD_ADD,   16'h0005, 16'h0005, 32'd9);
    send_command(CMD_LOAD,  16'h0005, 16'h0005, 32'd1);
    send_command(CMD_ADD,   16'h0005, 16'h0005, 32'd2);
    send_command(CMD_EMIT,  16'hffff, 16'hffff, 32'hffff_ffff);
  endtask

  // The output is held off while beats keep coming, so the input queue backs up.
  task automatic test_backpressure();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_pending = 1'b1;
    send_command(CMD_CLEAR, 16'h0, 16'h0, 32'h0);
    for (int i = 0; i < 8; i++) send_command(CMD_LOAD, 16'(i), 16'(i + 1), pick_value());
    send_command(CMD_EMIT, 16'h0, 16'h0, 32'h0);
    for (int i = 0; i < 8; i++) send_command(CMD_ADD, 16'($urandom_range(9)),
                                             16'($urandom_range(9)), pick_value());
    send_command(CMD_EMIT, 16'h0, 16'h0, 32'h0);
    send_command(CMD_EMIT, 16'h0, 16'h0, 32'h0);
    for (int i = 0; i < 4; i++) send_command(CMD_LOAD, 16'($urandom), 16'($urandom), $urandom);
    send_command(CMD_EMIT, 16'h0, 16'h0, 32'h0);
  endtask

  // Mostly clear, a run of loads and adds over a few keys, then emit; some stray beats too.
  // Long runs are load-heavy so that the table fills and overflows.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned beat_target);
    logic [KEY_FIELD_W-1:0] pool_row [4];
    logic [KEY_FIELD_W-1:0] pool_col [4];
    int unsigned            sent;
    int unsigned            run_len;
    bit                     long_run;
    logic [1:0]             cmd;
    logic [KEY_FIELD_W-1:0] r, c;
    int unsigned            pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    while (sent < beat_target) begin
      if ($urandom_range(9) == 0) begin
        send_command(2'($urandom_range(3)), 16'($urandom), 16'($urandom), $urandom);
        sent++;
      end else begin
        for (int i = 0; i < 4; i++) begin
          pool_row[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
          pool_col[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
        end
        if ($urandom_range(3) != 0) begin
          send_command(CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom);
          sent++;
        end
        long_run = ($urandom_range(3) == 0);
        run_len  = long_run ? $urandom_range(30, 40) : $urandom_range(1, 12);
        for (int i = 0; i < run_len; i++) begin
          if (long_run) cmd = ($urandom_range(3) == 0) ? CMD_ADD : CMD_LOAD;
          else cmd = ($urandom_range(2) == 0) ? CMD_LOAD : CMD_ADD;
          if ($urandom_range(4) == 0) begin
            r = 16'($urandom);
            c = 16'($urandom);
          end else begin
            pick = $urandom_range(3);
            r    = pool_row[pick];
            c    = pool_col[pick];
          end
          send_command(cmd, r, c, pick_value());
        end
        send_command(CMD_EMIT, 16'($urandom), 16'($urandom), $urandom);
        sent += run_len + 1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_accumulate();
    test_clear();
    test_backpressure();
    test_random_traffic(0, 0, 105);
    test_random_traffic(78, 0, 105);
    test_random_traffic(0, 78, 105);
    test_random_traffic(29, 29, 105);
    item_valid <= 1'b0;
    while (emitted_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (emitted_entries.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", emitted_entries.size()));
    if (mismatch_count == 0) begin
      $display("PASS sparse_triplet_accumulate_table_core");
    end else begin
      $display("FAIL sparse_triplet_accumulate_table_core");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/stat_pkg.sv
rtl/stat_front.sv
rtl/stat_queue.sv
rtl/stat_back.sv
rtl/sparse_triplet_accumulate_table_core.sv
tb/sv/sparse_triplet_accumulate_table_core_test.sv
